### rtl/positional_array_list_macros.svh
// Assertion macros shared by the positional array list RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional_array_list: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PAL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional_array_list: next-cycle check failed");

`endif

### rtl/pal_pkg.sv
// Shared constants, codes and types of the positional array list.
// No dependencies; used by pal_cell, pal_gather and positional_array_list.
package pal_pkg;

  localparam int CAPACITY    = 128;
  localparam int ENTRY_BITS  = 32;
  localparam int CMD_BITS    = 3;
  localparam int POS_BITS    = 8;
  localparam int COUNT_BITS  = 8;
  localparam int STATUS_BITS = 2;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_AT    = 3'd1,
    CMD_INS_BACK  = 3'd2,
    CMD_REM_FRONT = 3'd3,
    CMD_REM_AT    = 3'd4,
    CMD_REM_BACK  = 3'd5,
    CMD_READ_AT   = 3'd6
  } pal_cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } pal_status_e;

  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_REMOVE = 2'd2
  } pal_shift_e;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    pal_shift_e       op;
    logic [IDX_W-1:0] at;
    logic             rd_en;
  } pal_ctrl_t;

endpackage

### rtl/pal_cell.sv
// One storage cell of the list chain: holds one entry word.
// Depends on pal_pkg for widths and the control broadcast type.
module pal_cell (
  input  logic                           clk_i,
  input  logic [pal_pkg::IDX_W-1:0]      cell_idx_i,
  input  pal_pkg::pal_ctrl_t             ctrl_i,
  input  logic [pal_pkg::ENTRY_BITS-1:0] value_i,
  input  logic [pal_pkg::ENTRY_BITS-1:0] left_i,
  input  logic [pal_pkg::ENTRY_BITS-1:0] right_i,
  output logic [pal_pkg::ENTRY_BITS-1:0] entry_o,
  output logic [pal_pkg::ENTRY_BITS-1:0] rd_o
);

  logic [pal_pkg::ENTRY_BITS-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      pal_pkg::SH_INSERT: begin
        // take the lower neighbor above the gap, the new word at the gap
        if (cell_idx_i > ctrl_i.at) begin
          entry_d = left_i;
        end else if (cell_idx_i == ctrl_i.at) begin
          entry_d = value_i;
        end
      end
      pal_pkg::SH_REMOVE: begin
        // close the gap: take the upper neighbor from the target on
        if (cell_idx_i >= ctrl_i.at) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = (ctrl_i.rd_en && (cell_idx_i == ctrl_i.at)) ? entry_q : '0;

endmodule

### rtl/pal_gather.sv
// Two-level OR tree that collects the one selected cell word.
// Depends on pal_pkg; the first level is registered, the second feeds the output register.
module pal_gather (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic [pal_pkg::ENTRY_BITS-1:0] sel_i [pal_pkg::CAPACITY],
  output logic [pal_pkg::ENTRY_BITS-1:0] data_o
);

  logic [pal_pkg::ENTRY_BITS-1:0] grp_d [pal_pkg::NUM_GROUPS];
  logic [pal_pkg::ENTRY_BITS-1:0] grp_q [pal_pkg::NUM_GROUPS];

  for (genvar g = 0; g < pal_pkg::NUM_GROUPS; g++) begin : g_grp
    always_comb begin
      grp_d[g] = '0;
      for (int k = 0; k < pal_pkg::GROUP_SIZE; k++) begin
        if (g * pal_pkg::GROUP_SIZE + k < pal_pkg::CAPACITY) begin
          grp_d[g] = grp_d[g] | sel_i[g * pal_pkg::GROUP_SIZE + k];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (load_i) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  always_comb begin
    data_o = '0;
    for (int g = 0; g < pal_pkg::NUM_GROUPS; g++) begin
      data_o = data_o | grp_q[g];
    end
  end

endmodule

### rtl/positional_array_list.sv
// Positional array list: an ordered list of up to CAPACITY entry words kept
// packed from index 0, built as a chain of cells that all shift together.
// Each command (insert front / at / back, remove front / at / back, read at)
// gives one result beat: the removed or read word (zero otherwise), the count
// after the command, and a status (ok, full, empty, position out of range).
// A failed command leaves the list unchanged; command code 7 returns the count
// with status ok. The list itself updates at the edge that accepts the beat,
// and that same edge loads the registered first level of the read tree; its
// word and the side info then load the output register that offers the result
// beat. One command is in flight at a time; with no stall on the output a new
// beat is taken at the edge its predecessor's result is taken, and no new beat
// is taken while an earlier command is still in flight. Entries beyond the
// count are never read and need no clearing after reset.
// Depends on pal_pkg, pal_cell, pal_gather and positional_array_list_macros.svh.
module positional_array_list (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [pal_pkg::CMD_BITS-1:0]    cmd_i,
  input  logic [pal_pkg::POS_BITS-1:0]    position_i,
  input  logic [pal_pkg::ENTRY_BITS-1:0]  entry_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pal_pkg::ENTRY_BITS-1:0]  entry_out_o,
  output logic [pal_pkg::COUNT_BITS-1:0]  count_out_o,
  output logic [pal_pkg::STATUS_BITS-1:0] status_o
);

  // ---------------------------------------------------------------------
  // Handshake and control state
  // ---------------------------------------------------------------------
  logic                        busy_q, busy_d;
  logic                        s1_valid_q;
  logic                        out_valid_q, out_valid_d;
  logic                        in_fire, out_fire;

  logic [pal_pkg::CNT_W-1:0]   count_q, count_d;
  logic [pal_pkg::CNT_W-1:0]   s1_count_q;
  pal_pkg::pal_status_e        s1_status_q;

  logic [pal_pkg::ENTRY_BITS-1:0] entry_out_q;
  logic [pal_pkg::CNT_W-1:0]      count_out_q;
  pal_pkg::pal_status_e           status_out_q;

  pal_pkg::pal_status_e        status_d;
  pal_pkg::pal_ctrl_t          dec_ctrl;   // decoded, before gating by accept
  pal_pkg::pal_ctrl_t          cell_ctrl;

  logic [pal_pkg::CMP_W-1:0]   cnt_w, pos_w, at_w;
  logic [pal_pkg::CNT_W-1:0]   next_count;

  // Output drains this edge: the single item in flight leaves, so take the next.
  assign out_fire   = out_valid_q & ~out_stall_i;
  assign in_stall_o = busy_q & ~out_fire;
  assign in_fire    = in_valid_i & ~in_stall_o;

  // ---------------------------------------------------------------------
  // Command decode: status, shift operation and target index
  // ---------------------------------------------------------------------
  assign cnt_w = pal_pkg::CMP_W'(count_q);
  assign pos_w = pal_pkg::CMP_W'(position_i);

  always_comb begin
    status_d       = pal_pkg::ST_OK;
    dec_ctrl.op    = pal_pkg::SH_HOLD;
    dec_ctrl.at    = '0;
    dec_ctrl.rd_en = 1'b0;
    next_count     = count_q;
    at_w           = pos_w;
    case (cmd_i)
      pal_pkg::CMD_INS_FRONT, pal_pkg::CMD_INS_AT, pal_pkg::CMD_INS_BACK: begin
        if (cmd_i == pal_pkg::CMD_INS_FRONT) begin
          at_w = '0;
        end else if (cmd_i == pal_pkg::CMD_INS_BACK) begin
          at_w = cnt_w;
        end
        // full check first, then the position
        if (count_q == pal_pkg::CNT_W'(pal_pkg::CAPACITY)) begin
          status_d = pal_pkg::ST_FULL;
        end else if (at_w > cnt_w) begin
          status_d = pal_pkg::ST_RANGE;
        end else begin
          dec_ctrl.op = pal_pkg::SH_INSERT;
          dec_ctrl.at = at_w[pal_pkg::IDX_W-1:0];
          next_count  = count_q + pal_pkg::CNT_W'(1);
        end
      end
      pal_pkg::CMD_REM_FRONT, pal_pkg::CMD_REM_AT, pal_pkg::CMD_REM_BACK: begin
        if (cmd_i == pal_pkg::CMD_REM_FRONT) begin
          at_w = '0;
        end else if (cmd_i == pal_pkg::CMD_REM_BACK) begin
          at_w = cnt_w - pal_pkg::CMP_W'(1);
        end
        // empty check first, then the position
        if (count_q == '0) begin
          status_d = pal_pkg::ST_EMPTY;
        end else if (at_w >= cnt_w) begin
          status_d = pal_pkg::ST_RANGE;
        end else begin
          dec_ctrl.op    = pal_pkg::SH_REMOVE;
          dec_ctrl.at    = at_w[pal_pkg::IDX_W-1:0];
          dec_ctrl.rd_en = 1'b1;
          next_count     = count_q - pal_pkg::CNT_W'(1);
        end
      end
      pal_pkg::CMD_READ_AT: begin
        // count never exceeds capacity, so this also rejects a position past the end
        if (pos_w >= cnt_w) begin
          status_d = pal_pkg::ST_RANGE;
        end else begin
          dec_ctrl.at    = pos_w[pal_pkg::IDX_W-1:0];
          dec_ctrl.rd_en = 1'b1;
        end
      end
      default: begin
        // unused code: leave the list alone, report the count
        status_d = pal_pkg::ST_OK;
      end
    endcase
  end

  // Only an accepted beat may move the chain.
  always_comb begin
    cell_ctrl = dec_ctrl;
    if (!in_fire) begin
      cell_ctrl.op    = pal_pkg::SH_HOLD;
      cell_ctrl.rd_en = 1'b0;
    end
  end

  assign count_d = in_fire ? next_count : count_q;

  // ---------------------------------------------------------------------
  // Chain of cells
  // ---------------------------------------------------------------------
  logic [pal_pkg::ENTRY_BITS-1:0] cell_entry [pal_pkg::CAPACITY];
  logic [pal_pkg::ENTRY_BITS-1:0] cell_rd    [pal_pkg::CAPACITY];
  logic [pal_pkg::ENTRY_BITS-1:0] gather_data;

  for (genvar i = 0; i < pal_pkg::CAPACITY; i++) begin : g_cell
    logic [pal_pkg::ENTRY_BITS-1:0] left_w, right_w;

    // ends of the chain feed back their own word; at the last cell it lands past the count
    if (i == 0) begin : g_first
      assign left_w = cell_entry[i];
    end else begin : g_mid_l
      assign left_w = cell_entry[i-1];
    end
    if (i == pal_pkg::CAPACITY - 1) begin : g_last
      assign right_w = cell_entry[i];
    end else begin : g_mid_r
      assign right_w = cell_entry[i+1];
    end

    pal_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (pal_pkg::IDX_W'(i)),
      .ctrl_i     (cell_ctrl),
      .value_i    (entry_value_i),
      .left_i     (left_w),
      .right_i    (right_w),
      .entry_o    (cell_entry[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // Read tree: captures the pre-shift word at the accept edge.
  pal_gather u_gather (
    .clk_i  (clk_i),
    .load_i (in_fire),
    .sel_i  (cell_rd),
    .data_o (gather_data)
  );

  // ---------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------
  always_comb begin
    busy_d = busy_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end else if (out_fire) begin
      busy_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s1_valid_q) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      s1_valid_q  <= in_fire;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  // Payload: hold the side info beside the read tree, then load the output beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_count_q  <= next_count;
      s1_status_q <= status_d;
    end
    if (s1_valid_q) begin
      entry_out_q  <= gather_data;
      count_out_q  <= s1_count_q;
      status_out_q <= s1_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign entry_out_o = entry_out_q;
  assign count_out_o = pal_pkg::COUNT_BITS'(count_out_q);
  assign status_o    = status_out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "positional_array_list_macros.svh"

  logic cmd_failed;
  assign cmd_failed = in_fire && (status_d != pal_pkg::ST_OK);

  `PAL_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= pal_pkg::CNT_W'(pal_pkg::CAPACITY))
  `PAL_ASSERT_IMP(a_one_in_flight, clk_i, rst_ni, s1_valid_q, !out_valid_q)
  `PAL_ASSERT_IMP(a_idle_empty, clk_i, rst_ni, !busy_q, !s1_valid_q && !out_valid_q)
  `PAL_ASSERT_NXT(a_fail_holds, clk_i, rst_ni, cmd_failed, count_q == $past(count_q))

endmodule
